[hdl/lut3d_trilinear_color_map_top_assert.svh]
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map_top_assert.svh
// Assertion macros shared by the color map RTL.
// ----------------------------------------------------------------------------
`ifndef LUT3D_TRILINEAR_COLOR_MAP_TOP_ASSERT_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define L3D_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define L3D_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define L3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/l3d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_pkg
// Types, constants and helpers of the 3D LUT color map.
// ----------------------------------------------------------------------------
package l3d_pkg;

  localparam int L3D_MAX_GRID   = 17;
  localparam int L3D_IDX_W      = 13;
  localparam int L3D_CH_W       = 8;
  localparam int L3D_GRID_W     = 5;
  localparam int L3D_GRID_RESET = 17;
  localparam int L3D_FIFO_DEPTH = 16;
  localparam int L3D_ACC_W      = 32;
  localparam int L3D_CORNERS    = 8;

  // (255^3 - 1) / 2, rounding offset for half up
  localparam logic [L3D_ACC_W-1:0] L3D_HALF = 32'd8290687;
  localparam logic [L3D_CH_W-1:0]  L3D_CH_MAX = 8'd255;

  typedef enum logic {
    L3D_CMD_LOAD  = 1'b0,
    L3D_CMD_PIXEL = 1'b1
  } l3d_cmd_t;

  typedef struct packed {
    logic [L3D_CH_W-1:0] out_red;
    logic [L3D_CH_W-1:0] out_green;
    logic [L3D_CH_W-1:0] out_blue;
    logic                batch_end_out;
  } l3d_result_t;

  // floor(x / 255), exact for x below 65280
  function automatic logic [15:0] l3d_div255_small(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return 16'(s >> 8);
  endfunction

  // floor(x / 255) for any 32-bit x, reciprocal multiply
  function automatic logic [31:0] l3d_div255(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * 64'h0000_0000_8080_8081;
    return 32'(p >> 39);
  endfunction

endpackage

[hdl/l3d_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_if
// Valid/ready channel interfaces of the 3D LUT color map.
// ----------------------------------------------------------------------------
interface l3d_in_if import l3d_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [L3D_IDX_W-1:0] entry_index;
  logic [L3D_CH_W-1:0]  entry_red;
  logic [L3D_CH_W-1:0]  entry_green;
  logic [L3D_CH_W-1:0]  entry_blue;
  logic [L3D_CH_W-1:0]  pixel_red;
  logic [L3D_CH_W-1:0]  pixel_green;
  logic [L3D_CH_W-1:0]  pixel_blue;
  logic                 batch_end;

  modport source (output valid, command, entry_index, entry_red, entry_green, entry_blue,
                  pixel_red, pixel_green, pixel_blue, batch_end, input ready);
  modport sink   (input valid, command, entry_index, entry_red, entry_green, entry_blue,
                  pixel_red, pixel_green, pixel_blue, batch_end, output ready);
endinterface

interface l3d_out_if import l3d_pkg::*;;
  logic                valid;
  logic                ready;
  logic [L3D_CH_W-1:0] out_red;
  logic [L3D_CH_W-1:0] out_green;
  logic [L3D_CH_W-1:0] out_blue;
  logic                batch_end_out;

  modport source (output valid, out_red, out_green, out_blue, batch_end_out, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, batch_end_out, output ready);
endinterface

interface l3d_cfg_if import l3d_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [L3D_GRID_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink   (input valid, grid_size, output ready);
endinterface

[hdl/l3d_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module l3d_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4913
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/l3d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_front
// Per-axis split: lattice index, clamped upper index and fraction.
// ----------------------------------------------------------------------------
module l3d_front import l3d_pkg::*; #(
  parameter int MAX_GRID = L3D_MAX_GRID,
  localparam int NW = $clog2(MAX_GRID + 1),
  localparam int IW = $clog2(MAX_GRID)
) (
  input  logic                         clk,
  input  logic [2:0][L3D_CH_W-1:0]     pix,
  input  logic [NW-1:0]                n,
  output logic [2:0][IW-1:0]           lo,
  output logic [2:0][IW-1:0]           hi,
  output logic [2:0][L3D_CH_W-1:0]     rem
);

  localparam int PW = L3D_CH_W + NW;

  logic [2:0][PW-1:0]       prod_r;
  logic [2:0][IW-1:0]       lo_r, lo_nxt;
  logic [2:0][IW-1:0]       hi_r, hi_nxt;
  logic [2:0][L3D_CH_W-1:0] rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= PW'(pix[c]) * PW'(n - NW'(1));
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    logic [15:0] x;
    logic [15:0] q;
    logic [15:0] top;
    top = 16'(n) - 16'd1;
    for (int c = 0; c < 3; c++) begin
      x          = 16'(prod_r[c]);
      q          = l3d_div255_small(x);
      lo_nxt[c]  = IW'(q);
      rem_nxt[c] = 8'(x - 16'(q * 16'd255));
      hi_nxt[c]  = (q < top) ? IW'(q + 16'd1) : IW'(q);
    end
  end

  assign lo  = lo_r;
  assign hi  = hi_r;
  assign rem = rem_r;

endmodule

[hdl/l3d_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_lane
// One corner: address, cube copy, corner weight and weighted channels.
// ----------------------------------------------------------------------------
module l3d_lane import l3d_pkg::*; #(
  parameter int MAX_GRID = L3D_MAX_GRID,
  parameter int CORNER = 0,
  localparam int NW = $clog2(MAX_GRID + 1),
  localparam int NNW = $clog2(MAX_GRID * MAX_GRID + 1),
  localparam int IW = $clog2(MAX_GRID),
  localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [3*L3D_CH_W-1:0]        wdata,
  input  logic [NW-1:0]                n,
  input  logic [NNW-1:0]               nn,
  input  logic [2:0][IW-1:0]           lo,
  input  logic [2:0][IW-1:0]           hi,
  input  logic [2:0][L3D_CH_W-1:0]     rem,
  output logic [2:0][L3D_ACC_W-1:0]    prod
);

  localparam logic [2:0] CB = 3'(CORNER);

  logic [2:0][IW-1:0]        idx;
  logic [2:0][L3D_CH_W-1:0]  wgt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic [15:0]               wrg_r;
  logic [L3D_CH_W-1:0]       wb_r;
  logic [23:0]               w_r;
  logic [3*L3D_CH_W-1:0]     ent;
  logic [2:0][L3D_ACC_W-1:0] prod_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      idx[c] = CB[c] ? hi[c] : lo[c];
      wgt[c] = CB[c] ? rem[c] : L3D_CH_MAX - rem[c];
    end
    addr_nxt = AW'(idx[0]) + AW'(AW'(n) * AW'(idx[1])) + AW'(AW'(nn) * AW'(idx[2]));
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    wrg_r  <= 16'(wgt[0]) * 16'(wgt[1]);
    wb_r   <= wgt[2];
    w_r    <= 24'(wrg_r) * 24'(wb_r);
    for (int ch = 0; ch < 3; ch++) begin
      prod_r[ch] <= 32'(w_r) * 32'(ent[ch*L3D_CH_W +: L3D_CH_W]);
    end
  end

  l3d_ram #(
    .WIDTH (3 * L3D_CH_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (ent)
  );

  assign prod = prod_r;

endmodule

[hdl/l3d_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l3d_merge
// Sums the corner lanes and divides by 255^3 with rounding half up.
// ----------------------------------------------------------------------------
module l3d_merge import l3d_pkg::*; (
  input  logic                                      clk,
  input  logic [L3D_CORNERS-1:0][2:0][L3D_ACC_W-1:0] prod,
  output logic [2:0][L3D_CH_W-1:0]                  res
);

  logic [1:0][2:0][L3D_ACC_W-1:0] part_r;
  logic [2:0][L3D_ACC_W-1:0]      tot_r;
  logic [2:0][L3D_ACC_W-1:0]      q1_r;
  logic [2:0][L3D_ACC_W-1:0]      q2_r;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int h = 0; h < 2; h++) begin
        part_r[h][ch] <= prod[4*h][ch] + prod[4*h+1][ch] + prod[4*h+2][ch]
                       + prod[4*h+3][ch];
      end
      tot_r[ch] <= part_r[0][ch] + part_r[1][ch] + L3D_HALF;
      q1_r[ch]  <= l3d_div255(tot_r[ch]);
      q2_r[ch]  <= l3d_div255(q1_r[ch]);
    end
  end

  always_comb begin
    logic [L3D_ACC_W-1:0] q3;
    for (int ch = 0; ch < 3; ch++) begin
      q3      = l3d_div255(q2_r[ch]);
      res[ch] = (q3 > L3D_ACC_W'(L3D_CH_MAX)) ? L3D_CH_MAX : L3D_CH_W'(q3);
    end
  end

endmodule

[hdl/lut3d_trilinear_color_map_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map_top
// Trilinear 3D LUT color mapper, eight corner lanes and a merge tree.
//
// in_ch carries load transactions (command 0: write entry_index with the
// entry color) and pixel transactions (command 1). Loads give no output;
// each pixel gives one transaction on out_ch, in order, with batch_end copied.
// cfg_ch writes grid_size; write it only while the block is idle.
// Throughput: one load or pixel per clock on in_ch while in_ch is ready.
// Each lane owns a full copy of the cube, so all eight corners are read in
// the same cycle and a load writes all copies at once.
// Pixels run through front, lanes and merge with no stall, into the FIFO.
// A 16-entry output FIFO with a credit counter decouples the sides: in_ch
// stays ready while fewer than 16 pixels are in flight or queued, so a
// stalled receiver throttles input only once the FIFO could fill.
// Reset clears the pipeline valids, FIFO and credits and sets grid_size to
// 17 (or MAX_GRID if smaller); the cube contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "lut3d_trilinear_color_map_top_assert.svh"

module lut3d_trilinear_color_map_top import l3d_pkg::*; #(
  parameter int MAX_GRID = L3D_MAX_GRID
) (
  input  logic             clk,
  input  logic             rst_n,
  l3d_in_if.sink           in_ch,
  l3d_out_if.source        out_ch,
  l3d_cfg_if.sink          cfg_ch
);

  localparam int NW    = $clog2(MAX_GRID + 1);
  localparam int NNW   = $clog2(MAX_GRID * MAX_GRID + 1);
  localparam int IW    = $clog2(MAX_GRID);
  localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int NRST  = (L3D_GRID_RESET > MAX_GRID) ? MAX_GRID : L3D_GRID_RESET;
  localparam int FPW   = $clog2(L3D_FIFO_DEPTH);
  localparam int CW    = $clog2(L3D_FIFO_DEPTH + 1);
  localparam int LAT   = 9;

  logic [NW-1:0]  n_r, n_nxt;
  logic [NNW-1:0] nn_r;

  logic                   v1_r;
  logic                   cmd1_r;
  logic [L3D_IDX_W-1:0]   idx1_r;
  logic [3*L3D_CH_W-1:0]  ent1_r;
  logic [2:0][L3D_CH_W-1:0] pix1_r;
  logic                   be1_r;

  logic                   ld1;
  logic [2:1]             wv_r;
  logic [2:1][AW-1:0]     wa_r;
  logic [2:1][3*L3D_CH_W-1:0] wd_r;

  logic [LAT:1] pv_r, pv_nxt;
  logic [LAT:1] be_r;

  logic                   we;
  logic [2:0][IW-1:0]     lo, hi;
  logic [2:0][L3D_CH_W-1:0] rem;
  logic [L3D_CORNERS-1:0][2:0][L3D_ACC_W-1:0] prod;
  logic [2:0][L3D_CH_W-1:0] res;

  l3d_result_t    fifo_r [L3D_FIFO_DEPTH];
  l3d_result_t    head;
  logic [FPW-1:0] wp_r, rp_r;
  logic [CW-1:0]  fcnt_r, fcnt_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           in_acc, acc_pix, push, pop;

  // configuration
  always_comb begin
    if (cfg_ch.grid_size < L3D_GRID_W'(2)) begin
      n_nxt = NW'(2);
    end else if (32'(cfg_ch.grid_size) > 32'(MAX_GRID)) begin
      n_nxt = NW'(MAX_GRID);
    end else begin
      n_nxt = NW'(cfg_ch.grid_size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(NRST);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      n_r <= n_nxt;
    end
    nn_r <= NNW'(NNW'(n_r) * NNW'(n_r));
  end

  assign cfg_ch.ready = 1'b1;

  // input stage
  assign in_ch.ready = (cnt_r < CW'(L3D_FIFO_DEPTH));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign acc_pix     = in_acc && (in_ch.command == L3D_CMD_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
    if (in_acc) begin
      cmd1_r    <= in_ch.command;
      idx1_r    <= in_ch.entry_index;
      ent1_r    <= {in_ch.entry_blue, in_ch.entry_green, in_ch.entry_red};
      pix1_r[0] <= in_ch.pixel_red;
      pix1_r[1] <= in_ch.pixel_green;
      pix1_r[2] <= in_ch.pixel_blue;
      be1_r     <= in_ch.batch_end;
    end
  end

  assign ld1 = v1_r && (cmd1_r == L3D_CMD_LOAD) && (32'(idx1_r) < 32'(DEPTH));

  // loads land after the corner reads of earlier pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else begin
      wv_r <= {wv_r[1], ld1};
    end
    wa_r <= {wa_r[1], AW'(idx1_r)};
    wd_r <= {wd_r[1], ent1_r};
  end

  assign we = wv_r[2];

  // pipeline valids
  always_comb begin
    pv_nxt    = {pv_r[LAT-1:1], 1'b0};
    pv_nxt[1] = v1_r && (cmd1_r == L3D_CMD_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= pv_nxt;
    end
    be_r <= {be_r[LAT-1:1], be1_r};
  end

  l3d_front #(
    .MAX_GRID (MAX_GRID)
  ) u_front (
    .clk (clk),
    .pix (pix1_r),
    .n   (n_r),
    .lo  (lo),
    .hi  (hi),
    .rem (rem)
  );

  for (genvar k = 0; k < L3D_CORNERS; k++) begin : g_lane
    l3d_lane #(
      .MAX_GRID (MAX_GRID),
      .CORNER   (k)
    ) u_lane (
      .clk   (clk),
      .we    (we),
      .waddr (wa_r[2]),
      .wdata (wd_r[2]),
      .n     (n_r),
      .nn    (nn_r),
      .lo    (lo),
      .hi    (hi),
      .rem   (rem),
      .prod  (prod[k])
    );
  end

  l3d_merge u_merge (
    .clk  (clk),
    .prod (prod),
    .res  (res)
  );

  // output FIFO and credits
  assign push = pv_r[LAT];
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    fcnt_nxt = fcnt_r + CW'(push) - CW'(pop);
    cnt_nxt  = cnt_r + CW'(acc_pix) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FPW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FPW'(1);
      end
      fcnt_r <= fcnt_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wp_r] <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                        batch_end_out: be_r[LAT]};
    end
  end

  assign head                 = fifo_r[rp_r];
  assign out_ch.valid         = (fcnt_r != '0);
  assign out_ch.out_red       = head.out_red;
  assign out_ch.out_green     = head.out_green;
  assign out_ch.out_blue      = head.out_blue;
  assign out_ch.batch_end_out = head.batch_end_out;

  `L3D_ASSERT_ALWAYS(a_credit_bound, clk, rst_n, cnt_r <= CW'(L3D_FIFO_DEPTH),
                     "credit overflow")
  `L3D_ASSERT_ALWAYS(a_fifo_le_credit, clk, rst_n, fcnt_r <= cnt_r, "fifo exceeds credits")
  `L3D_ASSERT_IMPLY(a_push_room, clk, rst_n, push, fcnt_r != CW'(L3D_FIFO_DEPTH),
                    "push when full")
  `L3D_ASSERT_NEXT(a_credit_take, clk, rst_n, acc_pix && !pop,
                   cnt_r == $past(cnt_r) + CW'(1), "credit not taken")

endmodule
